FILE: design/lkv_pkg.sv
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Shared types for the cache cells and the top-level control.
// ----------------------------------------------------------------------------
package lkv_pkg;

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } state_t;

  // Update operation broadcast to every cell.
  typedef enum logic [1:0] {
    OP_NONE,
    OP_HIT,
    OP_FILL,
    OP_EVICT
  } op_t;

  // Request broadcast to every cell.
  typedef struct packed {
    op_t         op;
    logic        is_set;
    logic [31:0] key;
    logic [31:0] value;
  } cmd_t;

  // Search result handed from one cell to the next; the lowest slot wins.
  typedef struct packed {
    logic        hit_found;
    logic [31:0] hit_value;
    logic        lru_found;
    logic [31:0] lru_key;
  } link_t;

endpackage

FILE: design/lkv_cell.sv
// ----------------------------------------------------------------------------
// LRU key-value cache cell
// One slot of the cache: key, word and recency rank, with its part of the
// search chain and its own rank update.
// ----------------------------------------------------------------------------
module lkv_cell import lkv_pkg::*; #(
  parameter int ENTRIES = 16,
  parameter int INDEX   = 0,
  localparam int RW     = $clog2(ENTRIES),
  localparam int FW     = $clog2(ENTRIES + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          look,
  input  cmd_t          cmd,
  input  logic [FW-1:0] fill_count,
  input  logic [RW-1:0] limit,
  input  link_t         link_in,
  input  logic [RW-1:0] rank_in,
  output link_t         link_out,
  output logic [RW-1:0] rank_out
);

  logic [31:0]   key_q;
  logic [31:0]   value_q;
  logic [RW-1:0] rank;
  logic          sel;
  logic          lru;
  logic          occ;
  logic          match;
  logic          is_lru;
  logic          take_hit;
  logic          take_lru;

  // The slot is occupied while it lies below the fill count.
  assign occ      = FW'(INDEX) < fill_count;
  assign match    = occ && (key_q == cmd.key);
  assign is_lru   = occ && (rank == RW'(ENTRIES - 1));
  assign take_hit = match && !link_in.hit_found;
  assign take_lru = is_lru && !link_in.lru_found;

  // Search chain: a lower slot that already matched keeps priority.
  always_comb begin
    link_out = link_in;
    rank_out = rank_in;
    if (take_hit) begin
      link_out.hit_found = 1'b1;
      link_out.hit_value = value_q;
      rank_out           = rank;
    end
    if (take_lru) begin
      link_out.lru_found = 1'b1;
      link_out.lru_key   = key_q;
    end
  end

  // Selection flags captured at the end of the lookup cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= 1'b0;
      lru <= 1'b0;
    end else if (look) begin
      sel <= take_hit;
      lru <= take_lru;
    end
  end

  // Rank update and slot write.
  always_ff @(posedge clk) begin
    if (rst) begin
      rank <= '0;
    end else begin
      case (cmd.op)
        OP_HIT: begin
          if (sel) begin
            rank <= '0;
          end else if (occ && rank < limit) begin
            rank <= rank + 1'b1;
          end
        end
        OP_FILL: begin
          if (FW'(INDEX) == fill_count) begin
            rank <= '0;
          end else if (occ) begin
            rank <= rank + 1'b1;
          end
        end
        OP_EVICT: begin
          if (lru) begin
            rank <= '0;
          end else if (rank < limit) begin
            rank <= rank + 1'b1;
          end
        end
        default: begin
          rank <= rank;
        end
      endcase
    end
  end

  // Key and word storage.
  always_ff @(posedge clk) begin
    if ((cmd.op == OP_HIT && sel && cmd.is_set) ||
        (cmd.op == OP_FILL && FW'(INDEX) == fill_count) ||
        (cmd.op == OP_EVICT && lru)) begin
      value_q <= cmd.value;
    end
    if ((cmd.op == OP_FILL && FW'(INDEX) == fill_count) ||
        (cmd.op == OP_EVICT && lru)) begin
      key_q <= cmd.key;
    end
  end

endmodule

FILE: design/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// LRU key-value cache
// Fully associative key-value cache with least-recently-used replacement,
// built as a row of slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall) carries one request per
//   transaction: req_type 0 looks up key, req_type 1 stores value under key.
//   The output channel (out_valid, out_stall) returns one result per
//   request, in request order: hit, read_value, evicted and evicted_key.
//   A request passes through a lookup cycle, in which every cell
//   compares its key and the search chain through the cells picks the
//   matching slot and the least recent slot, and then an update cycle in
//   which all cells adjust their ranks and the chosen slot is written. The
//   result is written to the output register at the end of the update
//   cycle, and a new request is taken in the update cycle, so the block
//   takes a new request only while idle or as the last one is updated.
//   A result waiting in the output register does not block the lookup of
//   the next request; the update waits while out_stall holds the previous
//   result, and in_stall stays high meanwhile.
//   Reset empties the cache: the fill count and all ranks return to zero.
// ----------------------------------------------------------------------------
module lru_key_value_cache import lkv_pkg::*; #(
  parameter int ENTRIES = 16,
  localparam int RW     = $clog2(ENTRIES),
  localparam int FW     = $clog2(ENTRIES + 1)
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [31:0] key,
  input  logic [31:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        hit,
  output logic [31:0] read_value,
  output logic        evicted,
  output logic [31:0] evicted_key
);

  state_t        state;
  state_t        state_next;
  logic          req_set;
  logic [31:0]   req_key;
  logic [31:0]   req_value;
  logic [FW-1:0] fill_count;
  logic          hit_q;
  logic [31:0]   hit_value_q;
  logic [RW-1:0] hit_rank_q;
  logic [31:0]   lru_key_q;
  logic          out_free;
  logic          accept;
  logic          look;
  logic          upd;
  op_t           op;
  cmd_t          cmd;
  logic [RW-1:0] limit;
  link_t         links [ENTRIES+1];
  logic [RW-1:0] ranks [ENTRIES+1];

  assign out_free = !out_valid || !out_stall;
  assign look     = (state == ST_LOOKUP);
  assign accept   = in_valid && !in_stall;

  // Sequencer: next state and handshake.
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    upd        = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (out_free) begin
          upd        = 1'b1;
          in_stall   = 1'b0;
          state_next = in_valid ? ST_LOOKUP : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Request register.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_set   <= req_type;
      req_key   <= key;
      req_value <= value;
    end
  end

  // Update operation chosen from the lookup result.
  always_comb begin
    op    = OP_NONE;
    limit = RW'(ENTRIES - 1);
    if (upd) begin
      if (hit_q) begin
        op    = OP_HIT;
        limit = hit_rank_q;
      end else if (req_set) begin
        op = (fill_count == FW'(ENTRIES)) ? OP_EVICT : OP_FILL;
      end
    end
  end

  assign cmd.op     = op;
  assign cmd.is_set = req_set;
  assign cmd.key    = req_key;
  assign cmd.value  = req_value;

  // Row of slot cells with the search chain running from slot zero up.
  assign links[0] = '0;
  assign ranks[0] = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lkv_cell #(
      .ENTRIES (ENTRIES),
      .INDEX   (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .look       (look),
      .cmd        (cmd),
      .fill_count (fill_count),
      .limit      (limit),
      .link_in    (links[i]),
      .rank_in    (ranks[i]),
      .link_out   (links[i+1]),
      .rank_out   (ranks[i+1])
    );
  end

  // Lookup result captured at the end of the chain.
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_q <= 1'b0;
    end else if (look) begin
      hit_q <= links[ENTRIES].hit_found;
    end
  end

  always_ff @(posedge clk) begin
    if (look) begin
      hit_value_q <= links[ENTRIES].hit_value;
      hit_rank_q  <= ranks[ENTRIES];
      lru_key_q   <= links[ENTRIES].lru_key;
    end
  end

  // Occupancy count.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (op == OP_FILL) begin
      fill_count <= fill_count + 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (upd) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      hit         <= hit_q;
      read_value  <= (hit_q && !req_set) ? hit_value_q : 32'd0;
      evicted     <= (op == OP_EVICT);
      evicted_key <= (op == OP_EVICT) ? lru_key_q : 32'd0;
    end
  end

endmodule

FILE: verif/lkv_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU key-value cache checker
// Watches the request and result channels of the cache, keeps its own copy
// of the slot contents and recency ranks, predicts the result of every
// accepted request and compares each returned result against it in order.
// ----------------------------------------------------------------------------

// Request codes shared by the stimulus and the checker.
package lkv_tb_pkg;
  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_SET = 1'b1;
endpackage

module lkv_checker import lkv_tb_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        req_type,
  input  logic [31:0] key,
  input  logic [31:0] value,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        hit,
  input  logic [31:0] read_value,
  input  logic        evicted,
  input  logic [31:0] evicted_key,
  output int          mismatches,
  output int          backlog
);

  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
    logic        evicted;
    logic [31:0] evicted_key;
  } cache_result_t;

  // Shadow copy of the cache contents.
  logic [31:0]  slot_key  [ENTRIES];
  logic [31:0]  slot_value[ENTRIES];
  int unsigned  slot_rank [ENTRIES];
  int unsigned  slots_used;

  cache_result_t pending_results[$];
  int            fail_count;

  // Make slot s the most recent: every occupied slot more recent than limit
  // ages by one step.
  function automatic void make_recent(int unsigned s, int unsigned limit);
    for (int unsigned i = 0; i < slots_used; i++) begin
      if (slot_rank[i] < limit) begin
        slot_rank[i] = slot_rank[i] + 1;
      end
    end
    slot_rank[s] = 0;
  endfunction

  // Apply one request to the shadow cache and return the result it causes.
  function automatic cache_result_t apply_request(logic kind, logic [31:0] k,
                                                  logic [31:0] v);
    cache_result_t r;
    int unsigned   slot;
    int unsigned   oldest;
    bit            found;
    r     = '0;
    slot  = 0;
    found = 1'b0;
    for (int unsigned i = 0; i < slots_used; i++) begin
      if (!found && slot_key[i] == k) begin
        found = 1'b1;
        slot  = i;
      end
    end
    if (found) begin
      r.hit = 1'b1;
      make_recent(slot, slot_rank[slot]);
      if (kind == REQ_SET) begin
        slot_value[slot] = v;
      end else begin
        r.read_value = slot_value[slot];
      end
    end else if (kind == REQ_SET) begin
      if (slots_used < ENTRIES) begin
        // A free slot remains: fill it as the most recent entry.
        slot             = slots_used;
        slots_used       = slots_used + 1;
        slot_key[slot]   = k;
        slot_value[slot] = v;
        slot_rank[slot]  = ENTRIES;
        make_recent(slot, ENTRIES);
      end else begin
        // Cache full: replace the least recent slot, lowest slot on a tie.
        oldest = 0;
        for (int unsigned i = 0; i < ENTRIES; i++) begin
          if (slot_rank[i] > oldest) begin
            oldest = slot_rank[i];
            slot   = i;
          end
        end
        r.evicted        = 1'b1;
        r.evicted_key    = slot_key[slot];
        slot_key[slot]   = k;
        slot_value[slot] = v;
        make_recent(slot, slot_rank[slot]);
      end
    end
    return r;
  endfunction

  // Compare results in order and predict each accepted request.
  always @(posedge clk) begin
    cache_result_t want;
    if (rst) begin
      slots_used = 0;
      fail_count = 0;
      for (int i = 0; i < ENTRIES; i++) begin
        slot_rank[i] = 0;
      end
      pending_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result transaction with no request outstanding");
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, hit);
            fail_count++;
          end
          if (read_value !== want.read_value) begin
            $error("read_value: expected %08h, got %08h", want.read_value, read_value);
            fail_count++;
          end
          if (evicted !== want.evicted) begin
            $error("evicted: expected %0d, got %0d", want.evicted, evicted);
            fail_count++;
          end
          if (evicted_key !== want.evicted_key) begin
            $error("evicted_key: expected %08h, got %08h", want.evicted_key, evicted_key);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        pending_results.push_back(apply_request(req_type, key, value));
      end
    end
    mismatches <= fail_count;
    backlog    <= pending_results.size();
  end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU key-value cache testbench
// Drives a directed sequence through fill, hit, miss and replacement, then
// about a thousand random gets and sets over a small rotating key pool so
// that hits and evictions are frequent. Both channels idle at random and
// the result side holds off once for a long stretch to back up the cache.
// ----------------------------------------------------------------------------
module tb import lkv_tb_pkg::*;;

  localparam int RANDOM_REQUESTS = 1000;
  localparam int KEY_POOL_SIZE   = 24;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        req_type;
  logic [31:0] key;
  logic [31:0] value;
  logic        out_valid;
  logic        out_stall;
  logic        hit;
  logic [31:0] read_value;
  logic        evicted;
  logic [31:0] evicted_key;
  int          mismatches;
  int          backlog;

  logic [31:0] key_pool[KEY_POOL_SIZE];

  lru_key_value_cache uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .key         (key),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hit         (hit),
    .read_value  (read_value),
    .evicted     (evicted),
    .evicted_key (evicted_key)
  );

  lkv_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .key         (key),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hit         (hit),
    .read_value  (read_value),
    .evicted     (evicted),
    .evicted_key (evicted_key),
    .mismatches  (mismatches),
    .backlog     (backlog)
  );

  initial begin
    clk = 1'b0;
  end

  always #2 clk = ~clk;

  // Offer one request and hold it until the cache takes the transaction.
  task automatic send_request(input logic kind, input logic [31:0] k,
                              input logic [31:0] v);
    in_valid <= 1'b1;
    req_type <= kind;
    key      <= k;
    value    <= v;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
  endtask

  // Random gap before a request, except in the quiet window.
  task automatic idle_gap(input int index);
    if (!(index >= 400 && index < 600) && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Result side: random stalls, one long hold-off and one quiet window.
  initial begin
    int cycle;
    out_stall <= 1'b0;
    cycle = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      cycle++;
      if (cycle >= 1500 && cycle < 1700) begin
        out_stall <= 1'b1;
      end else if (cycle >= 2200 && cycle < 2700) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 12);
      end
    end
  end

  // Request side and verdict.
  initial begin
    int          wait_cycles;
    int unsigned pick;
    logic [31:0] k;
    in_valid <= 1'b0;
    req_type <= REQ_GET;
    key      <= '0;
    value    <= '0;
    rst      <= 1'b1;
    for (int i = 0; i < KEY_POOL_SIZE; i++) begin
      key_pool[i] = $urandom();
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty miss, extreme keys and values, fill to capacity,
    // then replacement of the least recent entry and a miss on its key.
    send_request(REQ_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(REQ_SET, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(REQ_GET, 32'h0000_0000, 32'h0000_0000);
    send_request(REQ_SET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(REQ_SET, 32'h0000_0000, 32'h1234_5678);
    send_request(REQ_GET, 32'hFFFF_FFFF, 32'hA5A5_A5A5);
    for (int i = 1; i <= 14; i++) begin
      send_request(REQ_SET, i, ~i);
    end
    send_request(REQ_SET, 32'h0000_0100, 32'h8000_0001);
    send_request(REQ_GET, 32'h0000_0000, 32'h0000_0000);
    send_request(REQ_SET, 32'hDEAD_BEEF, 32'h7FFF_FFFE);

    // Random: mostly keys from a pool a bit larger than the cache, so gets
    // hit and sets evict; the rest are fresh keys that mostly miss.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      idle_gap(n);
      if ($urandom_range(0, 99) < 2) begin
        key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)] = $urandom();
      end
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        k = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
      end else begin
        k = $urandom();
      end
      send_request($urandom_range(0, 1) ? REQ_SET : REQ_GET, k, $urandom());
    end
    in_valid <= 1'b0;

    // Drain outstanding results, then allow late extras to show up.
    wait_cycles = 0;
    while (backlog != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (10) @(posedge clk);
    if (mismatches == 0 && backlog == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: sim.f
design/lkv_pkg.sv
design/lkv_cell.sv
design/lru_key_value_cache.sv
verif/lkv_checker.sv
verif/tb.sv
